>>> rtl/rhs_pkg.sv
// ----------------------------------------------------------------------------
// rhs_pkg: shared types and constants for the raster horizontal shear
// Dimension limits, fixed-point format of the slope, register indexes and
// the rounding and dimension helpers used by the config and datapath blocks.
// ----------------------------------------------------------------------------
package rhs_pkg;

	localparam int MAX_DIM         = 4096;
	localparam int SLOPE_FRAC_BITS = 12;

	localparam int DIM_W   = 13;                   // width of the dimension registers
	localparam int SLOPE_W = 16;
	localparam int SHIFT_W = 16;                   // pad counts
	localparam int PIX_W   = 8;
	localparam int IDX_W   = $clog2(MAX_DIM);      // row / column position
	// k * slope, plus one bit: a right-shear image turned left mid-image keeps
	// stepping up from h * slope for up to MAX_DIM - 1 rows
	localparam int ACC_W   = IDX_W + SLOPE_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_SHEAR_SLOPE  = 2'd2,
		REG_SHEAR_LEFT   = 2'd3
	} reg_idx_t;

	// Settings seen by the datapath, products already registered.
	typedef struct packed {
		logic [IDX_W-1:0]   w_m1;      // effective width minus one
		logic [IDX_W-1:0]   h_m1;      // effective height minus one
		logic [SLOPE_W-1:0] slope;
		logic               left;
		logic [ACC_W-1:0]   prod_h;    // h * slope
		logic [ACC_W-1:0]   prod_hm1;  // (h - 1) * slope
	} cfg_t;

	// Effective dimension minus one: zero acts as one, large values clamp.
	function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] vm1;
		vm1 = v - DIM_W'(1);
		if (v == '0)
			return '0;
		else if (int'(v) > MAX_DIM)
			return IDX_W'(MAX_DIM - 1);
		else
			return vm1[IDX_W-1:0];
	endfunction

	// Round half up, drop the fraction, saturate to the pad width.
	function automatic logic [SHIFT_W-1:0] round_shift(input logic [ACC_W-1:0] acc);
		logic [ACC_W:0] sum;
		logic [ACC_W:0] whole;
		sum   = {1'b0, acc} + ((ACC_W+1)'(1) << (SLOPE_FRAC_BITS - 1));
		whole = sum >> SLOPE_FRAC_BITS;
		if (whole > (ACC_W+1)'({SHIFT_W{1'b1}}))
			return {SHIFT_W{1'b1}};
		else
			return whole[SHIFT_W-1:0];
	endfunction

endpackage

>>> rtl/rhs_if.sv
// ----------------------------------------------------------------------------
// rhs_if: channel interfaces of the raster horizontal shear
// Pixel input stream, result stream and configuration write channel, each
// a valid/ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------
interface rhs_pix_if;
	logic                     valid;
	logic                     ready;
	logic [rhs_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rhs_res_if;
	logic                        valid;
	logic                        ready;
	logic [rhs_pkg::PIX_W-1:0]   pixel_out;
	logic [rhs_pkg::SHIFT_W-1:0] pad_before;
	logic [rhs_pkg::SHIFT_W-1:0] pad_after;
	logic                        row_end;
	logic                        image_end;

	modport source (output valid, output pixel_out, output pad_before, output pad_after,
		output row_end, output image_end, input ready);
	modport sink   (input valid, input pixel_out, input pad_before, input pad_after,
		input row_end, input image_end, output ready);
endinterface

interface rhs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rhs_pkg::CFG_IDX_W-1:0]  index;
	logic [rhs_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/rhs_cfg.sv
// ----------------------------------------------------------------------------
// rhs_cfg: configuration registers of the raster horizontal shear
// Holds width, height, slope and direction, and registers the two products
// h*slope and (h-1)*slope that seed each image.
// ----------------------------------------------------------------------------
module rhs_cfg (
	input  logic               clk,
	input  logic               arst_n,
	rhs_cfg_if.sink            cfg,
	output rhs_pkg::cfg_t      settings
);

	logic [rhs_pkg::DIM_W-1:0]   width_q;
	logic [rhs_pkg::DIM_W-1:0]   height_q;
	logic [rhs_pkg::SLOPE_W-1:0] slope_q;
	logic                        left_q;
	logic [rhs_pkg::ACC_W-1:0]   prod_h_q;
	logic [rhs_pkg::ACC_W-1:0]   prod_hm1_q;

	logic [rhs_pkg::IDX_W-1:0]   w_m1;
	logic [rhs_pkg::IDX_W-1:0]   h_m1;
	logic [rhs_pkg::IDX_W:0]     h_eff;
	logic [rhs_pkg::ACC_W:0]     prod_h;
	logic [rhs_pkg::ACC_W-1:0]   prod_hm1;
	logic                        wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rhs_pkg::DIM_W'(512);
			height_q <= rhs_pkg::DIM_W'(512);
			slope_q  <= '0;
			left_q   <= 1'b0;
		end else if (wr) begin
			unique case (rhs_pkg::reg_idx_t'(cfg.index))
				rhs_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg.data[rhs_pkg::DIM_W-1:0];
				rhs_pkg::REG_IMAGE_HEIGHT: height_q <= cfg.data[rhs_pkg::DIM_W-1:0];
				rhs_pkg::REG_SHEAR_SLOPE:  slope_q  <= cfg.data[rhs_pkg::SLOPE_W-1:0];
				rhs_pkg::REG_SHEAR_LEFT:   left_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign w_m1  = rhs_pkg::dim_m1(width_q);
	assign h_m1  = rhs_pkg::dim_m1(height_q);
	assign h_eff = {1'b0, h_m1} + (rhs_pkg::IDX_W+1)'(1);

	assign prod_h   = (rhs_pkg::ACC_W+1)'(h_eff) * (rhs_pkg::ACC_W+1)'(slope_q);
	assign prod_hm1 = rhs_pkg::ACC_W'(h_m1) * rhs_pkg::ACC_W'(slope_q);

	// h*slope stays below 2^ACC_W since h never exceeds MAX_DIM
	always_ff @(posedge clk) begin
		prod_h_q   <= prod_h[rhs_pkg::ACC_W-1:0];
		prod_hm1_q <= prod_hm1;
	end

	always_comb begin
		settings.w_m1     = w_m1;
		settings.h_m1     = h_m1;
		settings.slope    = slope_q;
		settings.left     = left_q;
		settings.prod_h   = prod_h_q;
		settings.prod_hm1 = prod_hm1_q;
	end

endmodule

>>> rtl/rhs_core.sv
// ----------------------------------------------------------------------------
// rhs_core: pixel datapath of the raster horizontal shear
// Input register, raster position and shift tracking, and the result
// register that presents each pixel with its pad counts.
// ----------------------------------------------------------------------------
module rhs_core (
	input  logic          clk,
	input  logic          arst_n,
	input  rhs_pkg::cfg_t settings,
	rhs_pix_if.sink       pixels,
	rhs_res_if.source     results
);

	logic                        valid_s1;
	logic [rhs_pkg::PIX_W-1:0]   pixel_s1;

	logic                        out_valid_q;
	logic [rhs_pkg::PIX_W-1:0]   pixel_q;
	logic [rhs_pkg::SHIFT_W-1:0] pad_before_q;
	logic [rhs_pkg::SHIFT_W-1:0] pad_after_q;
	logic                        row_end_q;
	logic                        image_end_q;

	logic [rhs_pkg::IDX_W-1:0]   row_q;
	logic [rhs_pkg::IDX_W-1:0]   col_q;
	logic [rhs_pkg::ACC_W-1:0]   acc_q;
	logic [rhs_pkg::SHIFT_W-1:0] max_q;
	logic [rhs_pkg::SHIFT_W-1:0] rs_q;

	logic                        out_adv;
	logic                        s1_fire;
	logic                        first_pix;
	logic                        last_col;
	logic                        last_row;
	logic [rhs_pkg::ACC_W-1:0]   acc_cur;
	logic [rhs_pkg::SHIFT_W-1:0] max_cur;
	logic [rhs_pkg::SHIFT_W-1:0] rs_cur;
	logic [rhs_pkg::SHIFT_W-1:0] lead_pad;
	logic [rhs_pkg::SHIFT_W-1:0] after;
	logic [rhs_pkg::ACC_W-1:0]   acc_next;
	logic [rhs_pkg::ACC_W-1:0]   slope_ext;

	assign out_adv      = !out_valid_q || results.ready;
	assign s1_fire      = valid_s1 && out_adv;
	assign pixels.ready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pixels.ready)
			valid_s1 <= pixels.valid;
	end

	always_ff @(posedge clk) begin
		if (pixels.valid && pixels.ready)
			pixel_s1 <= pixels.pixel_in;
	end

	assign first_pix = (row_q == '0) && (col_q == '0);
	assign slope_ext = rhs_pkg::ACC_W'(settings.slope);

	always_comb begin
		// image start reloads the accumulator and the widest shift
		if (first_pix) begin
			acc_cur = settings.left ? '0 : settings.prod_h;
			max_cur = rhs_pkg::round_shift(settings.left ? settings.prod_hm1 : settings.prod_h);
		end else begin
			acc_cur = acc_q;
			max_cur = max_q;
		end
		rs_cur   = (col_q == '0) ? rhs_pkg::round_shift(acc_cur) : rs_q;
		lead_pad = (col_q == '0) ? rs_cur : '0;
		last_col = col_q >= settings.w_m1;
		last_row = row_q >= settings.h_m1;
		after    = (last_col && max_cur > rs_cur) ? max_cur - rs_cur : '0;
		if (settings.left)
			acc_next = acc_cur + slope_ext;
		else
			acc_next = (acc_cur > slope_ext) ? acc_cur - slope_ext : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			acc_q <= '0;
			max_q <= '0;
			rs_q  <= '0;
		end else if (s1_fire) begin
			max_q <= max_cur;
			rs_q  <= rs_cur;
			if (last_col) begin
				col_q <= '0;
				acc_q <= acc_next;
				row_q <= last_row ? '0 : row_q + rhs_pkg::IDX_W'(1);
			end else begin
				col_q <= col_q + rhs_pkg::IDX_W'(1);
				acc_q <= acc_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_adv)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			pixel_q      <= pixel_s1;
			pad_before_q <= lead_pad;
			pad_after_q  <= after;
			row_end_q    <= last_col;
			image_end_q  <= last_col && last_row;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.pixel_out  = pixel_q;
	assign results.pad_before = pad_before_q;
	assign results.pad_after  = pad_after_q;
	assign results.row_end    = row_end_q;
	assign results.image_end  = image_end_q;

endmodule

>>> rtl/raster_horizontal_shear.sv
// ----------------------------------------------------------------------------
// raster_horizontal_shear: streaming horizontal shear of an 8-bit raster
// Takes pixels in row-major order and tags each with the zero padding that
// widens every row to image_width plus the largest shift of the image.
// ----------------------------------------------------------------------------
// Usage:
//   pixels  : one pixel per transaction, row-major, rows of image_width.
//   results : one transaction per pixel: the pixel, pad_before on the first
//             pixel of a row, pad_after on the last, row_end and image_end.
//   cfg     : register writes (width, height, slope Q4.12, direction),
//             always ready; write between transactions only.
// A pixel transaction loads the input register; its result then moves into
// the result register, from which the result transaction is presented. One
// pixel per cycle sustained while results does not stall; the shift for
// each row comes from a running accumulator stepped by the slope once per
// row, and the image-start products h*slope and (h-1)*slope are held in
// registers.
// Reset clears the raster position and empties both stages; registers go
// to 512 x 512, slope 0, right shear. When results stalls, the input
// register still takes one more pixel if it is empty, then pixels.ready
// stays low until results.ready returns.
// ----------------------------------------------------------------------------
module raster_horizontal_shear (
	input  logic       clk,
	input  logic       arst_n,
	rhs_cfg_if.sink    cfg,
	rhs_pix_if.sink    pixels,
	rhs_res_if.source  results
);

	rhs_pkg::cfg_t settings;

	rhs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.settings (settings)
	);

	rhs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.settings (settings),
		.pixels   (pixels),
		.results  (results)
	);

endmodule

>>> rtl/rhs_checker.sv
// ----------------------------------------------------------------------------
// rhs_checker: port-level checks for the raster horizontal shear
// Watches the pixel and result channels of the top level over time.
// ----------------------------------------------------------------------------
module rhs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rhs_pkg::PIX_W-1:0]   pixel_out,
	input logic [rhs_pkg::SHIFT_W-1:0] pad_after,
	input logic                        row_end,
	input logic                        image_end
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(row_end))
		else $error("result changed while stalled");

	a_pad_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pad_after != '0 |-> row_end)
		else $error("pad_after outside row end");

	a_image_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

	// a fresh result needs the pixel transaction that filled the input register before it was loaded
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without input");

endmodule

bind raster_horizontal_shear rhs_checker u_rhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.pixel_out (results.pixel_out),
	.pad_after (results.pad_after),
	.row_end   (results.row_end),
	.image_end (results.image_end)
);
